[design/ace_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and constants for the altitude complementary estimator.
// ----------------------------------------------------------------------------
package ace_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RANGE_ALPHA = 3'd0;
    localparam logic [2:0] REG_BARO_ALPHA  = 3'd1;
    localparam logic [2:0] REG_VEL_GAIN    = 3'd2;
    localparam logic [2:0] REG_VEL_LEAK    = 3'd3;
    localparam logic [2:0] REG_DEADBAND    = 3'd4;
    localparam logic [2:0] REG_MAX_AGE     = 3'd5;
    localparam logic [2:0] REG_BARO_HOLD   = 3'd6;

    // Gravity in Q16.16 (9.81).
    localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_V_MUL1,
        ST_V_MUL2,
        ST_V_LEAK,
        ST_E_MUL1,
        ST_E_MUL2,
        ST_E_SUM,
        ST_E_GAIN,
        ST_E_DT,
        ST_E_DT2,
        ST_E_FINAL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_OUT
    } ace_state_t;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'(S32_MAX))
            r = S32_MAX;
        else if (v < 66'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // Round-to-nearest (ties away from zero) right shift of a signed value.
    function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                     input logic [5:0] s);
        logic [65:0] mag;
        logic [65:0] q;
        mag = v[65] ? 66'(-v) : 66'(v);
        q = (mag + (66'd1 << (s - 6'd1))) >> s;
        return v[65] ? -$signed(q) : $signed(q);
    endfunction

endpackage
`default_nettype wire

[design/altitude_complementary_estimator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// altitude_complementary_estimator_top
// Complementary altitude estimator with one shared multiplier and a
// restoring divider step unit under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Signals                                     Direction
//  input     in_valid, in_stall, operation..current_tick  into block
//  output    out_valid, out_stall, altitude..surface_mode out of block
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data    into block
//
// An estimate step also runs the 52-step divider for vertical speed, which
// a velocity update does not use; the divider is skipped when dt is zero.
// The single 33x33 multiplier is shared by all products, one per cycle.
// One request is worked on at a time; in_stall is high while busy and while
// a finished result is held by out_stall. A stalled result holds the output.
// Reset is asynchronous and restores the register defaults and zero state.
// ----------------------------------------------------------------------------
module altitude_complementary_estimator_top
    import ace_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire                 operation,
    input  wire signed [20:0]   accel_z,
    input  wire  [19:0]         step_time,
    input  wire signed [31:0]   baro_altitude,
    input  wire  [22:0]         range_distance,
    input  wire  [31:0]         range_timestamp,
    input  wire  [31:0]         current_tick,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic signed [31:0]  altitude,
    output logic signed [31:0]  vertical_speed,
    output logic signed [31:0]  integrated_velocity,
    output logic                surface_mode,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [2:0]          cfg_index,
    input  wire  [15:0]         cfg_data
);

    // Configuration registers.
    logic [15:0] range_alpha_reg, baro_alpha_reg, gain_reg, leak_reg;
    logic [15:0] deadband_reg, max_age_reg;
    logic        hold_reg;

    // State and working registers.
    ace_state_t         state_reg, state_next;
    logic signed [31:0] alt_reg, alt_next, vel_reg, vel_next, spd_reg, spd_next;
    logic               surf_reg, surf_next, seeded_reg, seeded_next;
    logic               fresh_reg, fresh_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [19:0]        dt_reg, dt_next;
    logic signed [31:0] baro_reg, baro_next;
    logic [22:0]        dist_reg, dist_next;
    logic signed [20:0] acc_reg, acc_next;
    logic signed [65:0] t_reg, t_next, u_reg, u_next;
    logic [19:0]        lo_reg, lo_next;
    // Divider state.
    logic [52:0]        rem_reg, rem_next;
    logic [51:0]        num_reg, num_next, quo_reg, quo_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    // Output register.
    logic               ovalid_reg, ovalid_next;

    // Shared multiplier operands and product.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = 66'(mul_a) * 66'(mul_b);

    logic [31:0]        age;
    logic signed [32:0] diff;
    logic [52:0]        trial;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || (ovalid_reg && out_stall);
    assign out_valid = ovalid_reg;
    assign altitude            = alt_reg;
    assign vertical_speed      = spd_reg;
    assign integrated_velocity = vel_reg;
    assign surface_mode        = surf_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_alpha_reg <= 16'd58982;
            baro_alpha_reg  <= 16'd58982;
            gain_reg        <= 16'd256;
            leak_reg        <= 16'd65208;
            deadband_reg    <= 16'd2621;
            max_age_reg     <= 16'd50;
            hold_reg        <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RANGE_ALPHA: range_alpha_reg <= cfg_data;
                REG_BARO_ALPHA:  baro_alpha_reg  <= cfg_data;
                REG_VEL_GAIN:    gain_reg        <= cfg_data;
                REG_VEL_LEAK:    leak_reg        <= cfg_data;
                REG_DEADBAND:    deadband_reg    <= cfg_data;
                REG_MAX_AGE:     max_age_reg     <= cfg_data;
                REG_BARO_HOLD:   hold_reg        <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // State register and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            alt_reg    <= '0;
            vel_reg    <= '0;
            spd_reg    <= '0;
            surf_reg   <= 1'b0;
            seeded_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            alt_reg    <= alt_next;
            vel_reg    <= vel_next;
            spd_reg    <= spd_next;
            surf_reg   <= surf_next;
            seeded_reg <= seeded_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        prev_reg  <= prev_next;
        dt_reg    <= dt_next;
        baro_reg  <= baro_next;
        dist_reg  <= dist_next;
        acc_reg   <= acc_next;
        t_reg     <= t_next;
        u_reg     <= u_next;
        lo_reg    <= lo_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
    end

    // Sequencer: next state and datapath.
    always_comb
    begin
        state_next  = state_reg;
        alt_next    = alt_reg;
        vel_next    = vel_reg;
        spd_next    = spd_reg;
        surf_next   = surf_reg;
        seeded_next = seeded_reg;
        fresh_next  = fresh_reg;
        prev_next   = prev_reg;
        dt_next     = dt_reg;
        baro_next   = baro_reg;
        dist_next   = dist_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        u_next      = u_reg;
        lo_next     = lo_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg && out_stall;
        mul_a       = '0;
        mul_b       = '0;
        age         = current_tick - range_timestamp;
        diff        = 33'(alt_reg) - 33'(prev_reg);
        trial       = {rem_reg[51:0], num_reg[51]} - {1'b0, 32'd0, dt_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ovalid_next)
                begin
                    dt_next   = step_time;
                    baro_next = baro_altitude;
                    dist_next = range_distance;
                    prev_next = alt_reg;
                    fresh_next = (age <= 32'(max_age_reg));
                    // Deadband on acceleration.
                    if (22'(accel_z) >= $signed({6'd0, deadband_reg}))
                        acc_next = 21'(22'(accel_z) - $signed({6'd0, deadband_reg}));
                    else if (22'(accel_z) <= -$signed({6'd0, deadband_reg}))
                        acc_next = 21'(22'(accel_z) + $signed({6'd0, deadband_reg}));
                    else
                        acc_next = '0;
                    state_next = operation ? ST_E_MUL1 : ST_V_MUL1;
                end
            end
            // a * dt
            ST_V_MUL1:
            begin
                mul_a  = 33'(acc_reg);
                mul_b  = $signed({13'd0, dt_reg});
                t_next = mul_p;
                state_next = ST_V_MUL2;
            end
            // (a * dt) * g; a*dt fits 41 bits, times 20-bit g in two halves.
            ST_V_MUL2:
            begin
                mul_a  = 33'(t_reg[65:0] >>> 20);
                mul_b  = $signed({13'd0, GRAVITY_Q16});
                u_next = (mul_p <<< 20);
                t_next = $signed({46'd0, t_reg[19:0]});
                state_next = ST_V_LEAK;
                // low part added in the leak step
            end
            ST_V_LEAK:
            begin
                mul_a  = t_reg[32:0];
                mul_b  = $signed({13'd0, GRAVITY_Q16});
                vel_next = sat32(66'(vel_reg) + rnd_shift(u_reg + mul_p, 6'd36));
                state_next = ST_E_FINAL;
                neg_next = 1'b0;
            end
            // Estimate: mode decision and first IIR product.
            ST_E_MUL1:
            begin
                if (fresh_reg)
                    surf_next = 1'b1;
                mul_a = $signed({17'd0, (fresh_reg || surf_reg) ? range_alpha_reg
                                                                : baro_alpha_reg});
                mul_b = 33'(alt_reg);
                t_next = mul_p;
                state_next = ST_E_MUL2;
            end
            ST_E_MUL2:
            begin
                mul_a = $signed({16'd0, 17'd65536 - {1'b0, surf_reg ? range_alpha_reg
                                                                    : baro_alpha_reg}});
                mul_b = surf_reg ? $signed({10'd0, dist_reg}) : 33'(baro_reg);
                t_next = rnd_shift(t_reg + mul_p, 6'd16);
                if (!surf_reg && !seeded_reg)
                begin
                    t_next = 66'(baro_reg);
                    seeded_next = 1'b1;
                end
                state_next = ST_E_GAIN;
            end
            ST_E_GAIN:
            begin
                mul_a  = $signed({17'd0, gain_reg});
                mul_b  = 33'(vel_reg);
                u_next = rnd_shift(mul_p, 6'd8);
                state_next = ST_E_DT;
            end
            // gv is at most 40 bits; the high half times dt comes first.
            ST_E_DT:
            begin
                mul_a   = 33'(u_reg >>> 20);
                mul_b   = $signed({13'd0, dt_reg});
                u_next  = (mul_p <<< 20);
                lo_next = u_reg[19:0];
                state_next = ST_E_DT2;
            end
            // The low half of gv times dt is added on.
            ST_E_DT2:
            begin
                mul_a  = $signed({13'd0, lo_reg});
                mul_b  = $signed({13'd0, dt_reg});
                u_next = u_reg + mul_p;
                state_next = ST_E_SUM;
            end
            ST_E_SUM:
            begin
                if (surf_reg)
                begin
                    if (fresh_reg)
                        alt_next = sat32(t_reg + rnd_shift(u_reg, 6'd20));
                end
                else if (hold_reg)
                    alt_next = sat32(t_reg);
                else
                    alt_next = sat32(t_reg + rnd_shift(u_reg, 6'd20));
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                if (dt_reg == 20'd0)
                begin
                    spd_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    neg_next = diff[32];
                    // numerator = |diff| << 20 plus dt/2, always below 2^52
                    num_next = 52'({(diff[32] ? 33'(-diff) : diff), 20'd0}
                                   + 53'(dt_reg >> 1));
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = 6'd52;
                    state_next = ST_DIV;
                end
            end
            // One restoring division step per cycle.
            ST_DIV:
            begin
                if (!trial[52])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[50:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[51:0], num_reg[51]};
                    quo_next = {quo_reg[50:0], 1'b0};
                end
                num_next = {num_reg[50:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = ST_DIV_END;
            end
            ST_DIV_END:
            begin
                if (quo_reg > 52'h8000_0000)
                    spd_next = neg_reg ? S32_MIN : S32_MAX;
                else
                    spd_next = sat32(neg_reg ? -$signed({14'd0, quo_reg})
                                             :  $signed({14'd0, quo_reg}));
                state_next = ST_OUT;
            end
            ST_E_FINAL:
            begin
                mul_a = 33'(vel_reg);
                mul_b = $signed({17'd0, leak_reg});
                vel_next = sat32(rnd_shift(mul_p, 6'd16));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // The input side never takes a request while a result is pending in work.
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("request taken while busy");
    // A held result keeps the input side stalled.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("request taken while a result is held");
    // Surface mode is sticky.
    a_surf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        surf_reg |=> surf_reg)
        else $error("surface mode cleared");
    // A stalled result holds its altitude.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(altitude)))
        else $error("stalled result changed");
    // No configuration write while an item is in work.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == ST_IDLE))
        else $error("configuration accepted while busy");
`endif

endmodule
`default_nettype wire
